// ===== design/mpbs_pkg.sv =====
// ----------------------------------------------------------------------------
// mpbs_pkg
// Shared constants, types and helpers of the multi-pattern byte search block.
// ----------------------------------------------------------------------------
package mpbs_pkg;

  // Search geometry
  localparam int NUM_PATTERNS    = 4;   // patterns actually searched (1..4)
  localparam int MAX_PATTERN_LEN = 8;   // window cells (1..8)
  localparam int OFFSET_BITS     = 32;  // internal offset counter width

  // Fixed by the register map and the result fields
  localparam int PAT_SLOTS  = 4;        // pattern register slots
  localparam int PAT_W      = 64;       // bits of one pattern register
  localparam int LEN_W      = 4;        // bits of one length register
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;
  localparam int OUT_OFS_W  = 32;
  localparam int PIDX_W     = 2;

  // Hit vector: one bit per (position, pattern slot), position major
  localparam int POS_W     = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
  localparam int HIT_W     = MAX_PATTERN_LEN * PAT_SLOTS;
  localparam int HIT_IDX_W = $clog2(HIT_W);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_ZERO  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_ONE   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_TWO   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_THREE = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_ZERO   = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_ONE    = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_TWO    = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_THREE  = CFG_IDX_W'(7);

  typedef logic [7:0]             byte_t;
  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [HIT_W-1:0]       hit_vec_t;
  typedef logic [PAT_SLOTS-1:0]   slot_mask_t;
  typedef logic [PAT_SLOTS-1:0][7:0] slot_bytes_t;

  // Byte handed from one window cell to its left neighbor
  typedef struct packed {
    byte_t data;
    logic  valid;
  } cell_link_t;

  // Hits of one or more consecutive positions, first position at base
  typedef struct packed {
    hit_vec_t hits;
    offset_t  base;
  } hit_entry_t;

  // Offset of a later position, stuck at the maximum
  function automatic offset_t offset_add_sat(offset_t base, logic [POS_W-1:0] pos);
    logic [OFFSET_BITS:0] sum;
    sum = {1'b0, base} + (OFFSET_BITS+1)'(pos);
    return sum[OFFSET_BITS] ? '1 : sum[OFFSET_BITS-1:0];
  endfunction

  function automatic offset_t offset_inc_sat(offset_t value);
    return (value == '1) ? value : value + OFFSET_BITS'(1);
  endfunction

endpackage

// ===== design/mpbs_if.sv =====
// ----------------------------------------------------------------------------
// mpbs channel interfaces
// Byte stream, result and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mpbs_stream_if import mpbs_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface mpbs_result_if import mpbs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [OUT_OFS_W-1:0]  match_offset;
  logic [PIDX_W-1:0]     pattern_index;
  logic                  run_end;

  modport source (output valid, output match_offset, output pattern_index,
                  output run_end, input ready);
  modport sink   (input valid, input match_offset, input pattern_index,
                  input run_end, output ready);
endinterface

interface mpbs_cfg_if import mpbs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/mpbs_cell.sv =====
// ----------------------------------------------------------------------------
// mpbs_cell
// One window cell: holds a stream byte, passes it left on a shift and
// compares it against this cell's byte of every pattern.
// ----------------------------------------------------------------------------
module mpbs_cell import mpbs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        shift,
  input  cell_link_t  link_in,
  output cell_link_t  link_out,
  input  slot_bytes_t pat_bytes,
  input  slot_mask_t  need,
  output slot_mask_t  ok
);

  byte_t held;
  logic  held_valid;

  // valid bit is control, byte is payload
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (shift) begin
      held_valid <= link_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      held <= link_in.data;
    end
  end

  assign link_out.data  = held;
  assign link_out.valid = held_valid;

  // a pattern shorter than this cell's place does not look here
  always_comb begin
    for (int p = 0; p < PAT_SLOTS; p++) begin
      ok[p] = !need[p] || (held_valid && (held == pat_bytes[p]));
    end
  end

endmodule

// ===== design/mpbs_serializer.sv =====
// ----------------------------------------------------------------------------
// mpbs_serializer
// Two-entry result buffer: a holding entry and an output entry that sends
// one hit per beat, lowest position and pattern first.
// ----------------------------------------------------------------------------
module mpbs_serializer import mpbs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  hit_entry_t entry,
  output logic       can_push,
  mpbs_result_if.source result
);

  logic                 h_valid;
  hit_entry_t           h_entry;
  logic                 s_valid;
  hit_vec_t             s_vec;
  offset_t              s_base;
  logic [HIT_IDX_W-1:0] first_idx;
  logic [POS_W-1:0]     first_pos;
  logic                 single;
  logic                 take;
  logic                 s_free;

  // lowest set hit
  always_comb begin
    first_idx = '0;
    for (int i = HIT_W - 1; i >= 0; i--) begin
      if (s_vec[i]) first_idx = HIT_IDX_W'(i);
    end
  end

  assign first_pos = POS_W'(first_idx >> 2);
  assign single    = ((s_vec & (s_vec - HIT_W'(1))) == '0);
  assign take      = s_valid && result.ready;
  assign s_free    = !s_valid || (take && single);
  assign can_push  = !h_valid || s_free;

  assign result.valid         = s_valid;
  assign result.pattern_index = first_idx[PIDX_W-1:0];
  assign result.match_offset  = OUT_OFS_W'(offset_add_sat(s_base, first_pos));
  assign result.run_end       = single;

  // holding entry
  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
    end else if (push) begin
      h_valid <= 1'b1;
    end else if (s_free) begin
      h_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      h_entry <= entry;
    end
  end

  // output entry
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (s_free) begin
      s_valid <= h_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_free) begin
      s_vec  <= h_entry.hits;
      s_base <= h_entry.base;
    end else if (take) begin
      s_vec <= s_vec & (s_vec - HIT_W'(1));
    end
  end

endmodule

// ===== design/multi_pattern_byte_search.sv =====
// ----------------------------------------------------------------------------
// multi_pattern_byte_search
// Exact search of a byte stream for up to four configured byte patterns.
// ----------------------------------------------------------------------------
// Usage:
//   cfg    : register writes, index 0..3 pattern bytes (byte k in bits 8k+7:8k),
//            index 4..7 pattern lengths (0 disables). Always ready; write only
//            while the block is idle.
//   stream : one byte per beat, final_byte marks the last byte of a stream.
//   result : one hit per beat (offset, pattern), in order of offset, then
//            pattern; run_end marks the last hit caused by a byte.
// Throughput: one stream byte per cycle. Hits leave at one per cycle while
//   result is ready, so the stream stalls only when a byte's position has hits
//   while both result entries are still full. A final byte starts a flush
//   sweep through the cell chain until it is empty, during which stream
//   ready is low; the last sweep step also waits for a free result entry.
// Hit path: a position is decided once eight bytes from it are held; its hits
//   pass through the holding entry and then the output entry to result.
// Reset: registers clear to zero, window empty, offset zero. After a flush the
//   stream state is back at reset while the registers are kept. A stalled
//   result holds its beat; the block keeps taking bytes until a hit meets full buffers.
// ----------------------------------------------------------------------------
module multi_pattern_byte_search import mpbs_pkg::*; (
  input logic clk,
  input logic rst,
  mpbs_stream_if.sink   stream,
  mpbs_result_if.source result,
  mpbs_cfg_if.sink      cfg
);

  // registers
  logic [PAT_SLOTS-1:0][PAT_W-1:0] pat_reg;
  logic [PAT_SLOTS-1:0][LEN_W-1:0] len_reg;

  // window chain
  cell_link_t           link [MAX_PATTERN_LEN];
  cell_link_t           link_tail;
  slot_mask_t           cell_ok [MAX_PATTERN_LEN];
  slot_mask_t           cell_need [MAX_PATTERN_LEN];
  slot_bytes_t          cell_bytes [MAX_PATTERN_LEN];
  logic [MAX_PATTERN_LEN-1:0] cell_valid;

  // control
  logic             check_pending;
  logic             flushing;
  logic [POS_W-1:0] sweep_cnt;
  logic [POS_W-1:0] eval_idx;
  hit_vec_t         acc;
  offset_t          flush_base;
  offset_t          oldest_offset;

  slot_mask_t pat_en;
  slot_mask_t hit4;
  logic       hit_any;
  logic       cell0_valid;
  hit_vec_t   acc_next;
  logic       sweep_last;
  logic       norm_block;
  logic       sweep_block;
  logic       sweep_step;
  logic       accept;
  logic       shift;
  logic       push;
  logic       can_push;
  hit_entry_t entry;

  // register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_reg <= '0;
      len_reg <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_PATTERN_ZERO:  pat_reg[0] <= cfg.data;
        REG_PATTERN_ONE:   pat_reg[1] <= cfg.data;
        REG_PATTERN_TWO:   pat_reg[2] <= cfg.data;
        REG_PATTERN_THREE: pat_reg[3] <= cfg.data;
        REG_LENGTH_ZERO:   len_reg[0] <= cfg.data[LEN_W-1:0];
        REG_LENGTH_ONE:    len_reg[1] <= cfg.data[LEN_W-1:0];
        REG_LENGTH_TWO:    len_reg[2] <= cfg.data[LEN_W-1:0];
        REG_LENGTH_THREE:  len_reg[3] <= cfg.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // pattern enables: searched slot, length 1..MAX_PATTERN_LEN
  always_comb begin
    for (int p = 0; p < PAT_SLOTS; p++) begin
      pat_en[p] = (p < NUM_PATTERNS) && (len_reg[p] != '0) &&
                  (len_reg[p] <= LEN_W'(MAX_PATTERN_LEN));
    end
  end

  // per-cell pattern bytes and length masks
  always_comb begin
    for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
      for (int p = 0; p < PAT_SLOTS; p++) begin
        cell_bytes[k][p] = pat_reg[p][8*k +: 8];
        cell_need[k][p]  = (LEN_W'(k) < len_reg[p]);
      end
    end
  end

  // new bytes enter at the right end, empty slots during the sweep
  assign link_tail.data  = stream.data_byte;
  assign link_tail.valid = !flushing;

  for (genvar k = 0; k < MAX_PATTERN_LEN; k++) begin : g_cell
    if (k == MAX_PATTERN_LEN - 1) begin : g_tail
      mpbs_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .shift     (shift),
        .link_in   (link_tail),
        .link_out  (link[k]),
        .pat_bytes (cell_bytes[k]),
        .need      (cell_need[k]),
        .ok        (cell_ok[k])
      );
    end else begin : g_body
      mpbs_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .shift     (shift),
        .link_in   (link[k+1]),
        .link_out  (link[k]),
        .pat_bytes (cell_bytes[k]),
        .need      (cell_need[k]),
        .ok        (cell_ok[k])
      );
    end
    assign cell_valid[k] = link[k].valid;
  end

  // hits at the position held in cell 0
  always_comb begin
    for (int p = 0; p < PAT_SLOTS; p++) begin
      hit4[p] = pat_en[p];
      for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
        hit4[p] = hit4[p] & cell_ok[k][p];
      end
    end
  end

  assign hit_any     = |hit4;
  assign cell0_valid = link[0].valid;

  // sweep accumulator with this position's hits merged in
  always_comb begin
    acc_next = acc;
    for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
      if (cell0_valid && (eval_idx == POS_W'(j))) begin
        acc_next[j*PAT_SLOTS +: PAT_SLOTS] = hit4;
      end
    end
  end

  // handshake and stall
  assign sweep_last  = flushing && (sweep_cnt == POS_W'(MAX_PATTERN_LEN - 1));
  assign norm_block  = check_pending && hit_any && !can_push;
  assign sweep_block = sweep_last && (acc_next != '0) && !can_push;
  assign sweep_step  = flushing && !sweep_block;
  assign stream.ready = !flushing && !norm_block;
  assign accept      = stream.valid && stream.ready;
  assign shift       = accept || sweep_step;

  // hand hits to the result buffer
  always_comb begin
    push  = 1'b0;
    entry = '0;
    if (check_pending && hit_any && can_push) begin
      push       = 1'b1;
      entry.hits = HIT_W'(hit4);
      entry.base = oldest_offset;
    end else if (sweep_step && sweep_last && (acc_next != '0)) begin
      push       = 1'b1;
      entry.hits = acc_next;
      entry.base = (eval_idx == '0) ? oldest_offset : flush_base;
    end
  end

  // stream control
  always_ff @(posedge clk) begin
    if (rst) begin
      check_pending <= 1'b0;
      flushing      <= 1'b0;
      sweep_cnt     <= '0;
      eval_idx      <= '0;
      acc           <= '0;
      oldest_offset <= '0;
    end else begin
      if (!norm_block) begin
        check_pending <= accept && !stream.final_byte;
      end

      if (accept && stream.final_byte) begin
        flushing <= 1'b1;
      end else if (sweep_step && sweep_last) begin
        flushing <= 1'b0;
      end

      if (sweep_step) begin
        if (sweep_last) begin
          sweep_cnt <= '0;
          eval_idx  <= '0;
          acc       <= '0;
        end else begin
          sweep_cnt <= sweep_cnt + POS_W'(1);
          acc       <= acc_next;
          if (cell0_valid) eval_idx <= eval_idx + POS_W'(1);
        end
      end

      // offset of cell 0 moves when a held byte leaves the chain
      if (sweep_step && sweep_last) begin
        oldest_offset <= '0;
      end else if (shift && cell0_valid) begin
        oldest_offset <= offset_inc_sat(oldest_offset);
      end
    end
  end

  // offset of the first swept position
  always_ff @(posedge clk) begin
    if (sweep_step && cell0_valid && (eval_idx == '0)) begin
      flush_base <= oldest_offset;
    end
  end

  mpbs_serializer u_serializer (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .entry    (entry),
    .can_push (can_push),
    .result   (result)
  );

  // checks
  a_final_starts_sweep: assert property (@(posedge clk) disable iff (rst)
    (accept && stream.final_byte) |=> (flushing && (sweep_cnt == '0) && (eval_idx == '0)))
    else $error("final byte did not start a clean flush sweep");

  a_sweep_empties_window: assert property (@(posedge clk) disable iff (rst)
    (sweep_step && sweep_last) |=> ((cell_valid == '0) && (oldest_offset == '0)))
    else $error("window not empty after flush sweep");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push |-> can_push)
    else $error("hits pushed into a full result buffer");

  a_no_check_in_sweep: assert property (@(posedge clk) disable iff (rst)
    flushing |-> !check_pending)
    else $error("position check pending during flush sweep");

endmodule
